### src/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared constants, codes and controller/datapath signal groups for the
// sorted date table floor lookup block.
// ----------------------------------------------------------------------------
package sdt_pkg;

	localparam int TABLE_DEPTH = 2048;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int YEAR_W      = 14;
	localparam int MONTH_W     = 7;
	localparam int DAY_W       = 7;
	localparam int KEY_W       = YEAR_W + MONTH_W + DAY_W;
	localparam int RATE_W      = 32;
	localparam int STATUS_W    = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		RES_OK    = 3'd0,
		RES_FULL  = 3'd1,
		RES_HIT   = 3'd2,
		RES_FLOOR = 3'd3,
		RES_NONE  = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic      idle;
		logic      load_item;
		logic      rd_mid;
		logic      step;
		logic      rd_pos;
		logic      rd_prev;
		logic      shift_init;
		logic      shift_rd;
		logic      shift_wr;
		logic      wr_item;
		logic      count_inc;
		logic      set_kind;
		res_kind_t kind;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic op_lookup;
		logic lo_lt_hi;
		logic exact;
		logic lo_zero;
		logic full;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

### src/sdt_in_if.sv
// ----------------------------------------------------------------------------
// sdt_in_if
// Request channel: insert or floor lookup item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [sdt_pkg::YEAR_W-1:0]  key_year;
	logic [sdt_pkg::MONTH_W-1:0] key_month;
	logic [sdt_pkg::DAY_W-1:0]   key_day;
	logic [sdt_pkg::RATE_W-1:0]  rate_value;

	modport source (
		output valid, operation, key_year, key_month, key_day, rate_value,
		input  ready
	);
	modport sink (
		input  valid, operation, key_year, key_month, key_day, rate_value,
		output ready
	);
endinterface

### src/sdt_out_if.sv
// ----------------------------------------------------------------------------
// sdt_out_if
// Response channel: status, exact hit flag and rate with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdt_out_if;
	logic                         valid;
	logic                         ready;
	logic [sdt_pkg::STATUS_W-1:0] status;
	logic                         exact_hit;
	logic [sdt_pkg::RATE_W-1:0]   rate_out;

	modport source (
		output valid, status, exact_hit, rate_out,
		input  ready
	);
	modport sink (
		input  valid, status, exact_hit, rate_out,
		output ready
	);
endinterface

### src/sdt_ctrl.sv
// ----------------------------------------------------------------------------
// sdt_ctrl
// Sequencer: binary search, entry check, shift for insert and result hand-off.
// ----------------------------------------------------------------------------
module sdt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  sdt_pkg::sts_t sts,
	output sdt_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SRCH   = 8'b0000_0010,
		ST_CMP    = 8'b0000_0100,
		ST_EVAL   = 8'b0000_1000,
		ST_PREV   = 8'b0001_0000,
		ST_SHCHK  = 8'b0010_0000,
		ST_SHWR   = 8'b0100_0000,
		ST_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.kind = sdt_pkg::RES_OK;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SRCH;
				end
			end
			ST_SRCH: begin
				if (sts.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_d    = ST_CMP;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_SRCH;
			end
			ST_EVAL: begin
				cmd.set_kind = 1'b1;
				if (sts.op_lookup) begin
					if (sts.exact) begin
						cmd.kind = sdt_pkg::RES_HIT;
						state_d  = ST_RESULT;
					end else if (sts.lo_zero) begin
						cmd.kind = sdt_pkg::RES_NONE;
						state_d  = ST_RESULT;
					end else begin
						cmd.set_kind = 1'b0;
						cmd.rd_prev  = 1'b1;
						state_d      = ST_PREV;
					end
				end else begin
					if (sts.exact) begin
						// same key, so rewriting the whole entry only changes the rate
						cmd.wr_item = 1'b1;
						cmd.kind    = sdt_pkg::RES_OK;
						state_d     = ST_RESULT;
					end else if (sts.full) begin
						cmd.kind = sdt_pkg::RES_FULL;
						state_d  = ST_RESULT;
					end else begin
						cmd.set_kind   = 1'b0;
						cmd.shift_init = 1'b1;
						state_d        = ST_SHCHK;
					end
				end
			end
			ST_PREV: begin
				cmd.set_kind = 1'b1;
				cmd.kind     = sdt_pkg::RES_FLOOR;
				state_d      = ST_RESULT;
			end
			ST_SHCHK: begin
				if (sts.shift_done) begin
					cmd.wr_item   = 1'b1;
					cmd.count_inc = 1'b1;
					cmd.set_kind  = 1'b1;
					cmd.kind      = sdt_pkg::RES_OK;
					state_d       = ST_RESULT;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = ST_SHWR;
				end
			end
			ST_SHWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = ST_SHCHK;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
	a_load_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> state_q == ST_SRCH)
		else $error("item load did not start a search");
	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE)
		else $error("result hand-off did not return to idle");
`endif

endmodule

### src/sdt_datapath.sv
// ----------------------------------------------------------------------------
// sdt_datapath
// Entry memory, search bounds, shift pointer, item registers and result
// register.
// ----------------------------------------------------------------------------
module sdt_datapath (
	input  logic          clk,
	input  logic          arst_n,
	sdt_in_if.sink        req,
	sdt_out_if.source     rsp,
	input  sdt_pkg::cmd_t cmd,
	output sdt_pkg::sts_t sts
);

	localparam int ENT_W = sdt_pkg::KEY_W + sdt_pkg::RATE_W;

	logic [ENT_W-1:0]              mem_q [sdt_pkg::TABLE_DEPTH];
	logic [ENT_W-1:0]              rd_q;
	logic                          op_q;
	logic [sdt_pkg::KEY_W-1:0]     key_q;
	logic [sdt_pkg::RATE_W-1:0]    rate_q;
	logic [sdt_pkg::CNT_W-1:0]     lo_q, hi_q, count_q, ptr_q;
	sdt_pkg::res_kind_t            kind_q;
	logic                          out_valid_q;
	logic [sdt_pkg::STATUS_W-1:0]  out_status_q;
	logic                          out_hit_q;
	logic [sdt_pkg::RATE_W-1:0]    out_rate_q;

	logic [sdt_pkg::CNT_W-1:0]     mid;
	logic [sdt_pkg::CNT_W-1:0]     rd_addr;
	logic [sdt_pkg::CNT_W-1:0]     wr_addr;
	logic [ENT_W-1:0]              wr_data;
	logic                          rd_en, wr_en;
	logic [sdt_pkg::KEY_W-1:0]     rd_key;
	logic [sdt_pkg::RATE_W-1:0]    rd_rate;

	assign rd_key  = rd_q[ENT_W-1:sdt_pkg::RATE_W];
	assign rd_rate = rd_q[sdt_pkg::RATE_W-1:0];
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	assign req.ready = cmd.idle;

	always_comb begin
		rd_en   = cmd.rd_mid | cmd.rd_pos | cmd.rd_prev | cmd.shift_rd;
		rd_addr = lo_q;
		if (cmd.rd_mid) begin
			rd_addr = mid;
		end else if (cmd.rd_prev) begin
			rd_addr = lo_q - 1'b1;
		end else if (cmd.shift_rd) begin
			rd_addr = ptr_q - 1'b1;
		end
		wr_en   = cmd.wr_item | cmd.shift_wr;
		wr_addr = cmd.shift_wr ? ptr_q : lo_q;
		wr_data = cmd.shift_wr ? rd_q : {key_q, rate_q};
	end

	// lo may equal the depth on a full table; that read wraps and is never used
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[sdt_pkg::IDX_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr[sdt_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= req.operation;
			key_q  <= {req.key_year, req.key_month, req.key_day};
			rate_q <= req.rate_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			kind_q  <= sdt_pkg::RES_OK;
		end else begin
			if (cmd.load_item) begin
				lo_q <= '0;
				hi_q <= count_q;
			end else if (cmd.step) begin
				if (rd_key < key_q) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.shift_init) begin
				ptr_q <= count_q;
			end else if (cmd.shift_wr) begin
				ptr_q <= ptr_q - 1'b1;
			end
			if (cmd.set_kind) begin
				kind_q <= cmd.kind;
			end
		end
	end

	// result register lets the next transaction in while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= sdt_pkg::STATUS_OK;
			out_hit_q    <= 1'b0;
			out_rate_q   <= '0;
			case (kind_q)
				sdt_pkg::RES_FULL:  out_status_q <= sdt_pkg::STATUS_FULL;
				sdt_pkg::RES_NONE:  out_status_q <= sdt_pkg::STATUS_NONE;
				sdt_pkg::RES_HIT: begin
					out_hit_q  <= 1'b1;
					out_rate_q <= rd_rate;
				end
				sdt_pkg::RES_FLOOR: out_rate_q <= rd_rate;
				default: ;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.exact_hit = out_hit_q;
	assign rsp.rate_out  = out_rate_q;

	assign sts.req_valid  = req.valid;
	assign sts.op_lookup  = (op_q == sdt_pkg::OP_LOOKUP);
	assign sts.lo_lt_hi   = (lo_q < hi_q);
	assign sts.exact      = (lo_q < count_q) && (rd_key == key_q);
	assign sts.lo_zero    = (lo_q == '0);
	assign sts.full       = (count_q == sdt_pkg::CNT_W'(sdt_pkg::TABLE_DEPTH));
	assign sts.shift_done = (ptr_q == lo_q);
	assign sts.out_free   = !out_valid_q || rsp.ready;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sdt_pkg::CNT_W'(sdt_pkg::TABLE_DEPTH))
		else $error("entry count above table depth");
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_q <= hi_q) && (hi_q <= count_q))
		else $error("search bounds out of order");
	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !sts.full)
		else $error("entry added to a full table");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten before hand-off");
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (ptr_q > lo_q) && (ptr_q <= count_q))
		else $error("shift pointer outside the moved range");
`endif

endmodule

### src/sorted_date_table_floor_lookup_core.sv
// ----------------------------------------------------------------------------
// sorted_date_table_floor_lookup_core
// Sorted (date, rate) table with insert/overwrite and floor lookup.
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   req      in   operation, key_year, key_month, key_day, rate_value
//   rsp      out  status, exact_hit, rate_out
//
// each binary search step reads the middle entry from the one memory read port
// and, with the read data registered, then moves one bound towards the key
// an insert of a new date moves each later entry up one place by a read and a write
// reset clears the entry count and the control registers, not the entry memory, which needs no clearing pass
// the result register holds a result while rsp is stalled; the next
// transaction is taken meanwhile and waits only for its own hand-off
// ----------------------------------------------------------------------------
module sorted_date_table_floor_lookup_core (
	input  logic      clk,
	input  logic      arst_n,
	sdt_in_if.sink    req,
	sdt_out_if.source rsp
);

	sdt_pkg::cmd_t cmd;
	sdt_pkg::sts_t sts;

	sdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sdt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

### tb/sdt_rate_table_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdt_rate_table_check_pkg
// Transaction types and scoreboard for the sorted date table: keeps its own
// sorted copy of the table, predicts each reply and checks the replies in order.
// ----------------------------------------------------------------------------
package sdt_rate_table_check_pkg;

	typedef struct packed {
		logic                        operation;
		logic [sdt_pkg::YEAR_W-1:0]  year;
		logic [sdt_pkg::MONTH_W-1:0] month;
		logic [sdt_pkg::DAY_W-1:0]   day;
		logic [sdt_pkg::RATE_W-1:0]  rate;
	} rate_request_t;

	typedef struct packed {
		logic [sdt_pkg::STATUS_W-1:0] status;
		logic                         exact_hit;
		logic [sdt_pkg::RATE_W-1:0]   rate;
	} rate_reply_t;

	class rate_table_scoreboard;
		logic [sdt_pkg::KEY_W-1:0]  date_keys[$];
		logic [sdt_pkg::RATE_W-1:0] date_rates[$];
		rate_reply_t                expected_replies[$];
		int errors;
		int inserts, overwrites, refused, lookups, exact_hits, floor_hits, not_found;
		int peak_entries;

		// first entry whose date is not below the key
		function int unsigned first_not_below(logic [sdt_pkg::KEY_W-1:0] key);
			int unsigned lo, hi, mid;
			lo = 0;
			hi = date_keys.size();
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (date_keys[mid] < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function void note_request(rate_request_t item);
			logic [sdt_pkg::KEY_W-1:0] key;
			int unsigned               pos;
			bit                        present;
			rate_reply_t               reply;
			key = {item.year, item.month, item.day};
			pos = first_not_below(key);
			present = pos < date_keys.size() && date_keys[pos] == key;
			reply = '0;
			if (item.operation == sdt_pkg::OP_INSERT) begin
				inserts++;
				if (present) begin
					// overwrite is allowed even with the table full
					date_rates[pos] = item.rate;
					overwrites++;
				end else if (date_keys.size() >= sdt_pkg::TABLE_DEPTH) begin
					reply.status = sdt_pkg::STATUS_FULL;
					refused++;
				end else begin
					date_keys.insert(pos, key);
					date_rates.insert(pos, item.rate);
					if (date_keys.size() > peak_entries)
						peak_entries = date_keys.size();
				end
			end else begin
				lookups++;
				if (present) begin
					reply.exact_hit = 1'b1;
					reply.rate = date_rates[pos];
					exact_hits++;
				end else if (pos == 0) begin
					reply.status = sdt_pkg::STATUS_NONE;
					not_found++;
				end else begin
					reply.rate = date_rates[pos - 1];
					floor_hits++;
				end
			end
			expected_replies.push_back(reply);
		endfunction

		function void check_reply(rate_reply_t got);
			rate_reply_t want;
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply: status %0d exact_hit %0d rate_out %h",
					$time, got.status, got.exact_hit, got.rate);
				return;
			end
			want = expected_replies.pop_front();
			if (got !== want) begin
				errors++;
				// fields are status/exact_hit/rate_out
				$display("%0t: reply mismatch: expected %0d/%0d/%h, actual %0d/%0d/%h",
					$time, want.status, want.exact_hit, want.rate,
					got.status, got.exact_hit, got.rate);
			end
		endfunction

		function int outstanding();
			return expected_replies.size();
		endfunction

		function int entries();
			return date_keys.size();
		endfunction

		function logic [sdt_pkg::KEY_W-1:0] any_stored_date();
			return date_keys[$urandom_range(0, date_keys.size() - 1)];
		endfunction
	endclass

endpackage

### tb/sorted_date_table_floor_lookup_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_date_table_floor_lookup_core_test
// Drives inserts and floor lookups with random gaps on both channels and
// checks every reply against a scoreboard model.
// ----------------------------------------------------------------------------
module sorted_date_table_floor_lookup_core_test;

	localparam int RANDOM_ITEMS   = 690;
	localparam int IDLE_PCT       = 31;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;

	sdt_in_if  req ();
	sdt_out_if rsp ();

	sorted_date_table_floor_lookup_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #4 clk = ~clk;

	sdt_rate_table_check_pkg::rate_table_scoreboard rate_sb;
	bit steady;
	bit hold_request;

	task automatic send(input logic op, input logic [sdt_pkg::KEY_W-1:0] key,
		input logic [sdt_pkg::RATE_W-1:0] rate);
		sdt_rate_table_check_pkg::rate_request_t item;
		item = sdt_rate_table_check_pkg::rate_request_t'({op, key, rate});
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.operation  <= item.operation;
		req.key_year   <= item.year;
		req.key_month  <= item.month;
		req.key_day    <= item.day;
		req.rate_value <= item.rate;
		do @(posedge clk); while (!req.ready);
		rate_sb.note_request(item);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (rate_sb.outstanding() != 0);
	endtask

	// mostly dates from a narrow window so that hits and floors are common
	function automatic logic [sdt_pkg::KEY_W-1:0] random_date();
		if ($urandom_range(0, 99) < 80)
			return {14'(2009 + $urandom_range(0, 3)), 7'($urandom_range(0, 13)),
				7'($urandom_range(0, 32))};
		return sdt_pkg::KEY_W'($urandom);
	endfunction

	function automatic logic [sdt_pkg::KEY_W-1:0] stored_or_random_date();
		if (rate_sb.entries() > 0 && $urandom_range(0, 99) < 70)
			return rate_sb.any_stored_date();
		return random_date();
	endfunction

	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			send(sdt_pkg::OP_INSERT, stored_or_random_date(), $urandom);
		else if (roll < 40)
			send(sdt_pkg::OP_INSERT, random_date(), $urandom);
		else if (roll < 65)
			send(sdt_pkg::OP_LOOKUP, stored_or_random_date(), $urandom);
		else
			send(sdt_pkg::OP_LOOKUP, random_date(), $urandom);
	endtask

	// watchdog: cycles in which neither channel moves a transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("sorted_date_table_floor_lookup_core regression: fail");
		$finish;
	end

	initial begin
		rate_sb = new();
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.operation  <= sdt_pkg::OP_INSERT;
		req.key_year   <= '0;
		req.key_month  <= '0;
		req.key_day    <= '0;
		req.rate_value <= '0;
		rsp.ready      <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		fork
			begin : reply_sink
				int hold_left;
				bit hold_done;
				hold_left = 0;
				hold_done = 0;
				forever begin
					@(posedge clk);
					if (rsp.valid && rsp.ready)
						rate_sb.check_reply(sdt_rate_table_check_pkg::rate_reply_t'(
							{rsp.status, rsp.exact_hit, rsp.rate_out}));
					if (hold_request && !hold_done) begin
						hold_done = 1;
						hold_left = HOLD_CYCLES;
					end
					if (hold_left > 0) begin
						hold_left--;
						rsp.ready <= 1'b0;
					end else begin
						rsp.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
					end
				end
			end
		join_none

		@(posedge clk);

		// empty table, below every date, exact, floor and overwrite
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd1, 7'd3}, $urandom);
		send(sdt_pkg::OP_INSERT, {14'd2011, 7'd1, 7'd3}, 32'h0001_2000);
		send(sdt_pkg::OP_LOOKUP, {14'd2010, 7'd12, 7'd31}, $urandom);
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd1, 7'd3}, $urandom);
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd1, 7'd4}, $urandom);
		send(sdt_pkg::OP_INSERT, '0, '0);
		send(sdt_pkg::OP_INSERT, '1, '1);
		send(sdt_pkg::OP_LOOKUP, '0, '1);
		send(sdt_pkg::OP_LOOKUP, '1, '0);
		send(sdt_pkg::OP_LOOKUP, {14'h3fff, 7'h7f, 7'h7e}, $urandom);
		send(sdt_pkg::OP_INSERT, {14'd2011, 7'd1, 7'd3}, 32'habcd_e000);
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd1, 7'd3}, $urandom);
		// out-of-range month and day compare as plain binary
		send(sdt_pkg::OP_INSERT, {14'd2011, 7'd99, 7'd99}, 32'h0000_0fff);
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd13, 7'd0}, $urandom);
		send(sdt_pkg::OP_LOOKUP, {14'd2011, 7'd100, 7'd0}, $urandom);
		send(sdt_pkg::OP_INSERT, {14'd8192, 7'd64, 7'd64}, 32'h5555_5555);
		send(sdt_pkg::OP_LOOKUP, {14'd8191, 7'd127, 7'd127}, $urandom);
		send(sdt_pkg::OP_LOOKUP, {14'd8192, 7'd64, 7'd65}, $urandom);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = i >= 300 && i < 420;
			if (i == 150)
				hold_request = 1;
			if (i == 520)
				wait_drained();
			random_item();
		end

		send(sdt_pkg::OP_INSERT, {14'd16381, 7'd1, 7'd1}, $urandom);
		send(sdt_pkg::OP_INSERT, {14'd2000, 7'd1, 7'd1}, $urandom);
		send(sdt_pkg::OP_INSERT, rate_sb.any_stored_date(), $urandom);
		send(sdt_pkg::OP_LOOKUP, '1, $urandom);
		for (int i = 0; i < 40; i++)
			random_item();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d inserts (%0d overwrites, %0d refused), %0d lookups",
			rate_sb.inserts, rate_sb.overwrites, rate_sb.refused, rate_sb.lookups);
		$display("lookups gave %0d exact, %0d floor, %0d not found; table peaked at %0d of %0d",
			rate_sb.exact_hits, rate_sb.floor_hits, rate_sb.not_found,
			rate_sb.peak_entries, sdt_pkg::TABLE_DEPTH);
		if (rate_sb.errors == 0 && rate_sb.outstanding() == 0)
			$display("sorted_date_table_floor_lookup_core regression: pass");
		else
			$display("sorted_date_table_floor_lookup_core regression: fail");
		$finish;
	end

endmodule

### filelist.f
src/sdt_pkg.sv
src/sdt_in_if.sv
src/sdt_out_if.sv
src/sdt_ctrl.sv
src/sdt_datapath.sv
src/sorted_date_table_floor_lookup_core.sv
tb/sdt_rate_table_check_pkg.sv
tb/sorted_date_table_floor_lookup_core_test.sv
